### rtl/bounded_mode_counter_macros.svh
// ----------------------------------------------------------------------------
// bounded mode counter assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MODE_COUNTER_MACROS_SVH
`define BOUNDED_MODE_COUNTER_MACROS_SVH

// property checked at every clock edge outside reset
`define BMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// consequent checked after the antecedent, by non-overlapping implication
`define BMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// shared types and codes of the bounded mode counter
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

   // command codes carried in the mode field
   localparam logic [1:0] CMD_ADVANCE  = 2'd0;
   localparam logic [1:0] CMD_LOAD     = 2'd1;
   localparam logic [1:0] CMD_RESET    = 2'd2;
   localparam logic [1:0] CMD_SET_MODE = 2'd3;

   // counting modes
   localparam logic [1:0] RUN_CLIP    = 2'd0;
   localparam logic [1:0] RUN_WRAP    = 2'd1;
   localparam logic [1:0] RUN_REVERSE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_BEGIN = 2'd0;
   localparam logic [1:0] CSR_END   = 2'd1;
   localparam logic [1:0] CSR_STEP  = 2'd2;

   // reset values
   localparam logic [31:0] BEGIN_RESET = 32'd0;
   localparam logic [31:0] END_RESET   = 32'd127;
   localparam logic [30:0] STEP_RESET  = 31'd1;

   // configuration registers
   typedef struct packed {
      logic [31:0] begin_value;
      logic [31:0] end_value;
      logic [30:0] step_size;
   } cfg_type;

   // counter state
   typedef struct packed {
      logic [31:0] count;
      logic        direction;
      logic [1:0]  run_mode;
   } state_type;

   // one command word
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] load_value;
      logic [1:0]  new_run_mode;
   } cmd_type;

   // outcome of one command
   typedef struct packed {
      state_type   next_state;
      logic        emit;
      logic [31:0] count_out;
      logic        boundary_hit;
   } result_type;

endpackage

`default_nettype wire

### rtl/bmc_csr.sv
// ----------------------------------------------------------------------------
// bmc_csr
// configuration registers: bounds and step size
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_csr
   import bmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BEGIN: cfg_in.begin_value = csr_write_data;
            CSR_END:   cfg_in.end_value   = csr_write_data;
            CSR_STEP:  cfg_in.step_size   = csr_write_data[30:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_value <= BEGIN_RESET;
         cfg_ff.end_value   <= END_RESET;
         cfg_ff.step_size   <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/bmc_step.sv
// ----------------------------------------------------------------------------
// bmc_step
// single pass datapath: next counter state and result for one command
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_step
   import bmc_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire state_type state,
   input  wire cmd_type   cmd,
   output result_type     result
);

   logic        ascending;
   logic        fwd;
   logic        sneg;
   logic        hit;
   logic [31:0] step_pos;
   logic [31:0] step_s;
   logic [31:0] step_a;
   logic [31:0] target;
   logic [31:0] root;
   logic [31:0] d_vt;
   logic [31:0] d_tv;
   logic [31:0] wrap_val;
   logic [31:0] wrap_diff;
   logic [31:0] wrap_fix;
   logic [31:0] rev_val;
   logic [31:0] rev_diff;
   logic [31:0] rev_fix;

   // direction, target bound and signed step
   assign ascending = $signed(cfg.begin_value) < $signed(cfg.end_value);
   assign fwd       = state.direction;
   assign sneg      = ascending ? ~fwd : fwd;
   assign step_pos  = {1'b0, cfg.step_size};
   assign step_s    = sneg ? (32'd0 - step_pos) : step_pos;
   assign step_a    = ascending ? step_pos : (32'd0 - step_pos);
   assign target    = fwd ? cfg.end_value : cfg.begin_value;
   assign root      = fwd ? cfg.begin_value : cfg.end_value;

   // at or past the target bound
   assign d_vt = state.count - target;
   assign d_tv = target - state.count;
   assign hit  = ~(sneg ? d_tv[31] : d_vt[31]);

   // wrap: fold by the span, clamp an overshoot to the target
   assign wrap_val  = state.count + cfg.begin_value - cfg.end_value;
   assign wrap_diff = sneg ? (target - wrap_val) : (wrap_val - target);
   assign wrap_fix  = (~wrap_diff[31] && (wrap_diff != 32'd0)) ? target : wrap_val;

   // reverse: reflect off the target, clamp to the far bound
   assign rev_val  = {target[30:0], 1'b0} - state.count;
   assign rev_diff = sneg ? (root - rev_val) : (rev_val - root);
   assign rev_fix  = rev_diff[31] ? root : rev_val;

   // command decode and state update
   always_comb begin
      result.next_state   = state;
      result.emit         = 1'b0;
      result.count_out    = state.count;
      result.boundary_hit = hit;
      case (cmd.mode)
         CMD_ADVANCE: begin
            result.emit = 1'b1;
            if (!hit) begin
               result.next_state.count = state.count + step_s;
            end else begin
               case (state.run_mode)
                  RUN_WRAP: begin
                     result.count_out        = wrap_fix;
                     result.next_state.count = wrap_fix + step_s;
                  end
                  RUN_REVERSE: begin
                     result.count_out            = rev_fix;
                     result.next_state.count     = rev_fix - step_s;
                     result.next_state.direction = ~fwd;
                  end
                  default: begin
                     result.count_out        = target;
                     result.next_state.count = target + step_s;
                  end
               endcase
            end
         end
         CMD_LOAD: begin
            result.next_state.count     = cmd.load_value;
            result.next_state.direction = 1'b1;
         end
         CMD_RESET: begin
            result.next_state.count = cfg.begin_value;
         end
         default: begin
            // set mode: re-aim the pending step when the direction turns forward
            case (cmd.new_run_mode)
               RUN_CLIP, RUN_WRAP: begin
                  result.next_state.run_mode  = cmd.new_run_mode;
                  result.next_state.direction = 1'b1;
                  if (!state.direction) begin
                     result.next_state.count = state.count + {step_a[30:0], 1'b0};
                  end
               end
               RUN_REVERSE: begin
                  result.next_state.run_mode = RUN_REVERSE;
               end
               default: begin
                  result.next_state = state;
               end
            endcase
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/bounded_mode_counter.sv
// ----------------------------------------------------------------------------
// bounded_mode_counter
// counter between two bounds with clip, wrap and reverse modes
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel (valid/stall), one word per command:
// advance, load, reset to begin, or set counting mode. Only an advance
// returns a word on the rsp_ channel: the count and a boundary flag.
// Bounds and step size are written through the csr_ port; the user must
// write them only while idle, unenforced by the block. A command is taken
// into an input register; the step logic executes it against the counter
// state and, for an advance, loads the response register. Throughput is
// one command per cycle unless a held response blocks an advance, set by
// the state update loop (add, compare and select on the registered count).
// When the receiver stalls, a held response blocks only a following
// advance in the input register; load, reset and mode commands still pass.
// Reset restores begin 0, end 127, step 1, count 0, forward, clip mode,
// and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_mode_counter
   import bmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_load_value,
   input  wire logic [1:0]  req_new_run_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_count_out,
   output logic             rsp_boundary_hit,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

`include "bounded_mode_counter_macros.svh"

   cfg_type    cfg;
   result_type result;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   cmd_type    s1_cmd_ff;
   state_type  state_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [31:0] rsp_count_ff;
   logic       rsp_hit_ff;
   logic       out_ready;
   logic       s1_fire;
   logic       req_accept;

   // configuration registers
   bmc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // command execution
   bmc_step u_step (
      .cfg    (cfg),
      .state  (state_ff),
      .cmd    (s1_cmd_ff),
      .result (result)
   );

   // handshake control
   assign out_ready  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire    = s1_valid_ff & ((s1_cmd_ff.mode != CMD_ADVANCE) | out_ready);
   assign req_stall  = s1_valid_ff & ~s1_fire;
   assign req_accept = req_valid & ~req_stall;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~s1_fire);
   assign rsp_valid_in = (s1_fire & result.emit) | (rsp_valid_ff & rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff.mode         <= req_mode;
         s1_cmd_ff.load_value   <= req_load_value;
         s1_cmd_ff.new_run_mode <= req_new_run_mode;
      end
   end

   // counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.count     <= BEGIN_RESET;
         state_ff.direction <= 1'b1;
         state_ff.run_mode  <= RUN_CLIP;
      end else if (s1_fire) begin
         state_ff <= result.next_state;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && result.emit) begin
         rsp_count_ff <= result.count_out;
         rsp_hit_ff   <= result.boundary_hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_out    = rsp_count_ff;
   assign rsp_boundary_hit = rsp_hit_ff;

   // assertions
   `BMC_ASSERT(a_stall_only_on_full, !req_stall || (s1_valid_ff && (s1_cmd_ff.mode == CMD_ADVANCE) && rsp_valid_ff && rsp_stall), "input stalled without a blocked advance")
   `BMC_ASSERT_NEXT(a_advance_responds, s1_fire && (s1_cmd_ff.mode == CMD_ADVANCE), rsp_valid_ff, "issued advance gave no response")
   `BMC_ASSERT_NEXT(a_load_forward, s1_fire && (s1_cmd_ff.mode == CMD_LOAD), state_ff.direction && (state_ff.count == $past(s1_cmd_ff.load_value)), "load did not set count and forward direction")
   `BMC_ASSERT_NEXT(a_no_spurious_rsp, s1_fire && (s1_cmd_ff.mode != CMD_ADVANCE) && !(rsp_valid_ff && rsp_stall), !rsp_valid_ff, "response raised by a non-advance command")

endmodule

`default_nettype wire
